>>> rtl/core/itcnm_pkg.sv
// Shared types and constants for the inverse tone curve nearest-match block.
`default_nettype none
package itcnm_pkg;

  localparam int VALUE_W = 18;  // curve entry width, signed
  localparam int IDX_W   = 8;   // table index width
  localparam int CHAN_W  = 2;   // channel field width
  localparam int PIX_W   = 8;   // pixel sample width
  localparam int SAMPLE_SHIFT = 8;  // sample/256

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_MAP   = 1'b1
  } itcnm_req_t;

  // Control travelling with a pixel search down the chain
  typedef struct packed {
    logic              valid;
    logic              chan_ok;
    logic [CHAN_W-1:0] chan;
  } itcnm_ctl_t;

endpackage
`default_nettype wire

>>> rtl/core/inverse_tone_curve_nearest_match.sv
// Top level of the inverse tone curve nearest-match block: write decode, compare chain, result port.
//
//   channel | direction | ports                                             | transfer
//   --------+-----------+---------------------------------------------------+--------------------
//   in_     | in        | req_type channel entry_index entry_value pixel_value | valid & !stall
//   out_    | out       | tone_index                                        | valid & !stall
//
// A pixel transfer enters a chain of TABLE_ENTRIES compare cells, one cell per table position;
// each cell registers the pixel, and out_valid comes from the last cell's register. The chain
// takes one pixel per cycle while no held result stalls it. A write transfer is held off
// while any pixel is still in the chain or its result is held at the output.
// Reset clears the in-flight flags and the pixel counter only; table entries are undefined
// until written, and there is no clearing pass.
// out_stall on a valid result freezes the whole chain, so it holds and in_stall rises with it.
`default_nettype none
module inverse_tone_curve_nearest_match #(
  parameter int TABLE_ENTRIES = 256,
  parameter int CHANNELS      = 3,
  parameter int FRAC_BITS     = 16
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire         [0:0]                    in_req_type,
  input  wire         [itcnm_pkg::CHAN_W-1:0]  in_channel,
  input  wire         [itcnm_pkg::IDX_W-1:0]   in_entry_index,
  input  wire signed  [itcnm_pkg::VALUE_W-1:0] in_entry_value,
  input  wire         [itcnm_pkg::PIX_W-1:0]   in_pixel_value,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic        [itcnm_pkg::IDX_W-1:0]   out_tone_index
);
  import itcnm_pkg::*;

  // Target is the sample shifted into the fraction format
  localparam int TARGET_W = FRAC_BITS;
  localparam int MAXW     = (VALUE_W > FRAC_BITS + 1) ? VALUE_W : FRAC_BITS + 1;
  localparam int DIFF_W   = MAXW + 1;
  localparam int ABS_W    = DIFF_W - 1;
  localparam int CNT_W    = $clog2(TABLE_ENTRIES + 1);

  logic adv;          // whole chain moves this cycle
  logic in_xfer;
  logic pix_xfer;
  logic wr_xfer;
  logic out_xfer;
  logic chan_ok;
  logic busy;

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  // Links between cells; link 0 is fed straight from the input port
  itcnm_ctl_t          ctl_w    [TABLE_ENTRIES+1];
  logic [TARGET_W-1:0] target_w [TABLE_ENTRIES+1];
  logic [ABS_W-1:0]    best_w   [TABLE_ENTRIES+1];
  logic [IDX_W-1:0]    idx_w    [TABLE_ENTRIES+1];

  // Advance unless a finished result is held by the receiver
  assign adv      = !(out_valid && out_stall);
  assign busy     = (cnt_r != '0);
  // Hold writes while a pixel still reads the table
  assign in_stall = !adv || (busy && (in_req_type == REQ_WRITE));
  assign in_xfer  = in_valid && !in_stall;
  assign pix_xfer = in_xfer && (in_req_type == REQ_MAP);
  assign wr_xfer  = in_xfer && (in_req_type == REQ_WRITE);
  assign chan_ok  = ({1'b0, in_channel} < (CHAN_W + 1)'(CHANNELS));

  assign ctl_w[0]    = '{valid: pix_xfer, chan_ok: chan_ok, chan: in_channel};
  assign target_w[0] = TARGET_W'(in_pixel_value) << (FRAC_BITS - SAMPLE_SHIFT);
  assign best_w[0]   = '0;
  assign idx_w[0]    = '0;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    itcnm_cell #(
      .CHANNELS (CHANNELS),
      .IDX      (g),
      .TARGET_W (TARGET_W),
      .DIFF_W   (DIFF_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .wr_en    (wr_xfer && chan_ok),
      .wr_chan  (in_channel),
      .wr_index (in_entry_index),
      .wr_value (in_entry_value),
      .ctl_i    (ctl_w[g]),
      .target_i (target_w[g]),
      .best_i   (best_w[g]),
      .idx_i    (idx_w[g]),
      .ctl_o    (ctl_w[g+1]),
      .target_o (target_w[g+1]),
      .best_o   (best_w[g+1]),
      .idx_o    (idx_w[g+1])
    );
  end

  // Last cell's register is the output register
  assign out_valid      = ctl_w[TABLE_ENTRIES].valid;
  assign out_tone_index = idx_w[TABLE_ENTRIES];
  assign out_xfer       = out_valid && !out_stall;

  // Count pixels between input transfer and output transfer
  always_comb begin
    cnt_nxt = cnt_r;
    if (pix_xfer && !out_xfer) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (!pix_xfer && out_xfer) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Unused tail of the chain: target, distance and channel fields leave the last cell unread
  logic unused_tail;
  assign unused_tail = ^{target_w[TABLE_ENTRIES], best_w[TABLE_ENTRIES],
                         ctl_w[TABLE_ENTRIES].chan_ok, ctl_w[TABLE_ENTRIES].chan};

endmodule
`default_nettype wire

>>> rtl/core/itcnm_cell.sv
// One compare cell: holds one table position for every channel and updates the running best match.
`default_nettype none
module itcnm_cell #(
  parameter int CHANNELS = 3,
  parameter int IDX      = 0,
  parameter int TARGET_W = 16,
  parameter int DIFF_W   = 19
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 adv,
  input  wire                                 wr_en,
  input  wire         [itcnm_pkg::CHAN_W-1:0]  wr_chan,
  input  wire         [itcnm_pkg::IDX_W-1:0]   wr_index,
  input  wire signed  [itcnm_pkg::VALUE_W-1:0] wr_value,
  input  itcnm_pkg::itcnm_ctl_t                ctl_i,
  input  wire         [TARGET_W-1:0]           target_i,
  input  wire         [DIFF_W-2:0]             best_i,
  input  wire         [itcnm_pkg::IDX_W-1:0]   idx_i,
  output itcnm_pkg::itcnm_ctl_t                ctl_o,
  output logic        [TARGET_W-1:0]           target_o,
  output logic        [DIFF_W-2:0]             best_o,
  output logic        [itcnm_pkg::IDX_W-1:0]   idx_o
);
  import itcnm_pkg::*;

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ABS_W = DIFF_W - 1;

  logic signed [VALUE_W-1:0] val_r [CHANNELS];
  logic signed [VALUE_W-1:0] sel;
  logic signed [DIFF_W-1:0]  diff;
  logic        [ABS_W-1:0]   absd;
  logic                      take;

  itcnm_ctl_t        ctl_r;
  logic [TARGET_W-1:0] target_r;
  logic [ABS_W-1:0]    best_r;
  logic [IDX_W-1:0]    idx_r;

  // Table storage; write only this cell's position
  always_ff @(posedge clk) begin
    if (wr_en && (wr_index == IDX_W'(IDX))) begin
      val_r[wr_chan[CH_W-1:0]] <= wr_value;
    end
  end

  always_comb begin
    sel  = val_r[ctl_i.chan[CH_W-1:0]];
    diff = DIFF_W'(sel) - DIFF_W'($signed({1'b0, target_i}));
    absd = diff[DIFF_W-1] ? ABS_W'(-diff) : ABS_W'(diff);
    // First cell seeds the best for any valid channel; later cells need a strictly smaller distance
    if (IDX == 0) begin
      take = ctl_i.chan_ok;
    end else begin
      take = ctl_i.chan_ok && (absd < best_i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      target_r <= target_i;
      best_r   <= take ? absd : best_i;
      idx_r    <= take ? IDX_W'(IDX) : idx_i;
    end
  end

  assign ctl_o    = ctl_r;
  assign target_o = target_r;
  assign best_o   = best_r;
  assign idx_o    = idx_r;

endmodule
`default_nettype wire

>>> rtl/core/itcnm_checker.sv
// Port-level checker for the inverse tone curve nearest-match block, bound to the top level.
`default_nettype none
module itcnm_checker (
  input wire                                 clk,
  input wire                                 rst_n,
  input wire                                 in_valid,
  input wire                                 in_stall,
  input wire [0:0]                           in_req_type,
  input wire                                 out_valid,
  input wire                                 out_stall,
  input wire [itcnm_pkg::IDX_W-1:0]          out_tone_index
);
  import itcnm_pkg::*;

  // Nothing leaves right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A held result freezes the chain, so the input side must stall too
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("input taken while result is held");

  // After a pixel transfer with no result out, the input side stays free for another pixel unless a result is then out
  a_pix_then_free: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_req_type == REQ_MAP) && !out_valid)
    |=> (!in_stall || (in_req_type == REQ_WRITE) || out_valid))
    else $error("pixel input stalled with an idle output");

  // Held result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_tone_index)))
    else $error("held result changed");

endmodule

bind inverse_tone_curve_nearest_match itcnm_checker u_itcnm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_req_type    (in_req_type),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_tone_index (out_tone_index)
);
`default_nettype wire
